/* rtl/core/dec96_pkg.sv */
package dec96_pkg;

    localparam int MANT_W  = 96;
    localparam int SCALE_W = 5;

    typedef logic [MANT_W-1:0]  mant_t;
    typedef logic [SCALE_W-1:0] scale_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_POS_OVF = 2'd1,
        ST_NEG_OVF = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TRIM_A,
        S_TRIM_B,
        S_UP_B,
        S_UP_A,
        S_RND_A,
        S_RND_B,
        S_ADD,
        S_RETRY_A,
        S_RETRY_B,
        S_TRIM_R,
        S_OUT
    } fsm_t;

    // divide-by-ten unit result
    typedef struct packed {
        mant_t      quo;
        logic [3:0] rem;
    } div10_t;

endpackage

/* rtl/core/dec96_div10.sv */
module dec96_div10
    import dec96_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   start,
    input  logic   ack,
    input  mant_t  din,
    output logic   busy,
    output logic   done,
    output div10_t dout
);

    // long division by ten, one 32-bit limb per cycle from the top limb down
    // the top limb is divided in the start cycle, the other two follow
    logic [35:0] limb_in;
    logic [35:0] q0, q1, q2, q3, q4, q_est, r_est;
    logic [31:0] limb_quo;
    logic [3:0]  limb_rem;
    logic        fix;

    mant_t       quo_reg, quo_next;
    logic [3:0]  rem_reg, rem_next;
    logic        sel_reg, sel_next;     // 1: middle limb next, 0: low limb next
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    always_comb begin
        if (start) limb_in = {4'd0, din[95:64]};
        else if (sel_reg) limb_in = {rem_reg, quo_reg[63:32]};
        else limb_in = {rem_reg, quo_reg[31:0]};
        // reciprocal estimate by shifts and adds, low by at most one
        q0       = (limb_in >> 1) + (limb_in >> 2);
        q1       = q0 + (q0 >> 4);
        q2       = q1 + (q1 >> 8);
        q3       = q2 + (q2 >> 16);
        q4       = q3 + (q3 >> 32);
        q_est    = q4 >> 3;
        r_est    = limb_in - ((q_est << 3) + (q_est << 1));
        fix      = (r_est > 36'd9);
        limb_quo = q_est[31:0] + {31'd0, fix};
        limb_rem = fix ? (r_est[3:0] - 4'd10) : r_est[3:0];
    end

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        sel_next  = sel_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (ack) done_next = 1'b0;
        if (start) begin
            quo_next  = {limb_quo, din[63:0]};
            rem_next  = limb_rem;
            sel_next  = 1'b1;
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            if (sel_reg) quo_next[63:32] = limb_quo;
            else quo_next[31:0] = limb_quo;
            rem_next = limb_rem;
            if (!sel_reg) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            sel_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        sel_reg <= sel_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign dout.quo = quo_reg;
    assign dout.rem = rem_reg;

endmodule

/* rtl/core/decimal96_add_subtract.sv */
// decimal96_add_subtract: adds or subtracts two 96-bit decimals
// (magnitude, power-of-ten scale, sign)
// s_axis: one beat per operation; tdata holds op, a and b fields
// m_axis: one beat per result; tdata holds the result and status
// each operation runs through a small sequencer that reuses one
// divide-by-ten unit and one 96-bit adder/subtractor:
//   trim a, trim b, scale up the lower one, round the higher one,
//   add or subtract, round both and retry on carry, trim result
// the divide-by-ten unit works one 32-bit limb per cycle, so a pass
// through it is start, two limbs, then take the result; the sequencer
// takes a new operation only after the last result has been taken
// s_axis_tready is high only while the sequencer is idle; the result
// sits in the output register until m_axis_tready takes it, so a
// stalled receiver holds the block and no result is lost
// reset (aresetn low, synchronous) returns the sequencer to idle and
// drops any result not yet taken
module decimal96_add_subtract
    import dec96_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // op[0], a_mant_low[64:1], a_mant_high[96:65], a_scale[101:97],
    // a_negative[102], b_mant_low[166:103], b_mant_high[198:167],
    // b_scale[203:199], b_negative[204], zero fill
    input  logic [207:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // r_mant_low[63:0], r_mant_high[95:64], r_scale[100:96],
    // r_negative[101], status[103:102]
    output logic [103:0] m_axis_tdata
);

    fsm_t    state_reg, state_next;
    mant_t   a_reg, a_next, b_reg, b_next, r_reg, r_next;
    scale_t  sa_reg, sa_next, sb_reg, sb_next;
    logic    na_reg, na_next, nb_reg, nb_next, neg_reg, neg_next;
    status_t st_reg, st_next;

    // shared divide-by-ten operand select
    mant_t   div_in;
    div10_t  div_out;
    mant_t   div_rnd;
    logic    rnd_up;
    logic    div_need, div_start, div_ack, div_busy, div_done;

    // adder, subtractors and times-ten arithmetic
    logic [MANT_W:0] sum;
    logic [MANT_W:0] diff;
    logic [MANT_W+3:0] x10;
    mant_t   mul_in;
    logic    mul_ok;

    dec96_div10 u_div10 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .ack     (div_ack),
        .din     (div_in),
        .busy    (div_busy),
        .done    (div_done),
        .dout    (div_out)
    );

    always_comb begin
        case (state_reg)
            S_TRIM_A, S_RND_A, S_RETRY_A: div_in = a_reg;
            S_TRIM_B, S_RND_B, S_RETRY_B: div_in = b_reg;
            default:                      div_in = r_reg;
        endcase
        // states that need a divide-by-ten result this pass
        case (state_reg)
            S_TRIM_A:             div_need = (sa_reg != '0);
            S_TRIM_B:             div_need = (sb_reg != '0);
            S_RND_A:              div_need = (sa_reg > sb_reg);
            S_RND_B:              div_need = (sb_reg > sa_reg);
            S_RETRY_A, S_RETRY_B: div_need = 1'b1;
            S_TRIM_R:             div_need = (sa_reg != '0) && (r_reg != '0);
            default:              div_need = 1'b0;
        endcase
        div_start = div_need && !div_busy && !div_done;
        div_ack   = div_need && div_done;
        // half to even on the dropped digit
        rnd_up  = (div_out.rem > 4'd5) || (div_out.rem == 4'd5 && div_out.quo[0]);
        div_rnd = div_out.quo + mant_t'(rnd_up);
        mul_in  = (state_reg == S_UP_A) ? a_reg : b_reg;
        x10     = {1'b0, mul_in, 3'b000} + {3'b000, mul_in, 1'b0};
        mul_ok  = (mul_in[95:93] == 3'b000) && (x10[99:96] == 4'd0);
        sum     = {1'b0, a_reg} + {1'b0, b_reg};
        diff    = {1'b0, a_reg} - {1'b0, b_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        a_reg   <= a_next;
        b_reg   <= b_next;
        r_reg   <= r_next;
        sa_reg  <= sa_next;
        sb_reg  <= sb_next;
        na_reg  <= na_next;
        nb_reg  <= nb_next;
        neg_reg <= neg_next;
        st_reg  <= st_next;
    end

    always_comb begin
        state_next = state_reg;
        a_next = a_reg;   b_next = b_reg;   r_next = r_reg;
        sa_next = sa_reg; sb_next = sb_reg;
        na_next = na_reg; nb_next = nb_reg; neg_next = neg_reg;
        st_next = st_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    a_next  = s_axis_tdata[96:1];
                    sa_next = s_axis_tdata[101:97];
                    na_next = s_axis_tdata[102];
                    b_next  = s_axis_tdata[198:103];
                    sb_next = s_axis_tdata[203:199];
                    nb_next = s_axis_tdata[204] ^ s_axis_tdata[0];
                    st_next = ST_OK;
                    state_next = S_TRIM_A;
                end
            end
            S_TRIM_A: begin
                if (!div_need) state_next = S_TRIM_B;
                else if (div_done) begin
                    if (div_out.rem == 4'd0) begin
                        a_next = div_out.quo;
                        sa_next = sa_reg - 1'b1;
                    end else state_next = S_TRIM_B;
                end
            end
            S_TRIM_B: begin
                if (!div_need) state_next = S_UP_B;
                else if (div_done) begin
                    if (div_out.rem == 4'd0) begin
                        b_next = div_out.quo;
                        sb_next = sb_reg - 1'b1;
                    end else state_next = S_UP_B;
                end
            end
            S_UP_B: begin
                if (sb_reg < sa_reg && mul_ok) begin
                    b_next = x10[95:0];
                    sb_next = sb_reg + 1'b1;
                end else state_next = S_UP_A;
            end
            S_UP_A: begin
                if (sa_reg < sb_reg && mul_ok) begin
                    a_next = x10[95:0];
                    sa_next = sa_reg + 1'b1;
                end else state_next = S_RND_A;
            end
            S_RND_A: begin
                if (!div_need) state_next = S_RND_B;
                else if (div_done) begin
                    a_next = div_rnd;
                    sa_next = sa_reg - 1'b1;
                end
            end
            S_RND_B: begin
                if (!div_need) state_next = S_ADD;
                else if (div_done) begin
                    b_next = div_rnd;
                    sb_next = sb_reg - 1'b1;
                end
            end
            S_ADD: begin
                if (na_reg == nb_reg) begin
                    neg_next = na_reg;
                    r_next = sum[95:0];
                    if (!sum[96]) state_next = S_TRIM_R;
                    else if (sa_reg != '0) state_next = S_RETRY_A;
                    else begin
                        st_next = na_reg ? ST_NEG_OVF : ST_POS_OVF;
                        r_next = '0;
                        sa_next = '0;
                        neg_next = 1'b0;
                        state_next = S_TRIM_R;
                    end
                end else begin
                    if (!diff[96]) begin
                        r_next = diff[95:0];
                        neg_next = na_reg;
                    end else begin
                        r_next = b_reg - a_reg;
                        neg_next = nb_reg;
                    end
                    state_next = S_TRIM_R;
                end
            end
            S_RETRY_A: begin
                if (div_done) begin
                    a_next = div_rnd;
                    sa_next = sa_reg - 1'b1;
                    state_next = S_RETRY_B;
                end
            end
            S_RETRY_B: begin
                if (div_done) begin
                    b_next = div_rnd;
                    sb_next = sb_reg - 1'b1;
                    state_next = S_ADD;
                end
            end
            S_TRIM_R: begin
                if (div_need && div_done && div_out.rem == 4'd0) begin
                    r_next = div_out.quo;
                    sa_next = sa_reg - 1'b1;
                end else if (!div_need || div_done) begin
                    if (r_reg == '0) begin
                        sa_next = '0;
                        neg_next = 1'b0;
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (m_axis_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = {st_reg, neg_reg, sa_reg, r_reg};

`ifndef SYNTHESIS
    a_no_both: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input and output both open");
    a_ovf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && st_reg != ST_OK |-> r_reg == '0 && !neg_reg)
        else $error("overflow result not cleared");
    a_zero_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && r_reg == '0 |-> !neg_reg && sa_reg == '0)
        else $error("zero result not normalized");
`endif

endmodule
